// ===== rtl/core/lttc_pkg.sv =====
// Shared types and constants of the tile tag cache.
package lttc_pkg;

  localparam int SLOTS     = 64;
  localparam int MAX_NODES = 256;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);

  localparam logic [1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [1:0] CMD_INSERT     = 2'd1;
  localparam logic [1:0] CMD_INVALIDATE = 2'd2;
  localparam logic [1:0] CMD_FIND_DIRTY = 2'd3;

  localparam logic [1:0] KIND_MATCH  = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_EVICT  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  tree_level;
    logic [62:0] tile_number;
    logic [8:0]  node_total;
    logic        dirty_in;
    logic [6:0]  scan_start;
  } lttc_req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot_number;
    logic [5:0]  level_out;
    logic [62:0] tile_out;
    logic [8:0]  nodes_out;
    logic        dirty_out;
    logic [1:0]  insert_kind;
    logic [6:0]  next_scan;
  } lttc_rsp_t;

  typedef struct packed {
    logic [63:0] age;
    logic [5:0]  level;
    logic [62:0] tile;
    logic [8:0]  nodes;
    logic        dirty;
  } lttc_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_ACT
  } lttc_state_t;

endpackage

// ===== rtl/core/lttc_ifs.sv =====
// Handshake channels of the tile tag cache: request, response, configuration.
interface lttc_req_if;
  logic                valid;
  logic                ready;
  lttc_pkg::lttc_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lttc_rsp_if;
  logic                valid;
  logic                ready;
  lttc_pkg::lttc_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lttc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lttc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lttc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/core/lttc_ctrl.sv =====
// Command sequencer: slot scan, target selection, read-modify-write and response.
module lttc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  lttc_req_if.sink              req,
  lttc_rsp_if.source            rsp,
  lttc_cfg_if.sink              cfg,
  output logic                  ram_wr_en,
  output logic [lttc_pkg::IDX_W-1:0] ram_wr_addr,
  output lttc_pkg::lttc_entry_t ram_wr_data,
  output logic                  ram_rd_en,
  output logic [lttc_pkg::IDX_W-1:0] ram_rd_addr,
  input  lttc_pkg::lttc_entry_t ram_rd_data
);
  import lttc_pkg::*;

  lttc_state_t state, state_next;

  logic [6:0]       slots_in_use;
  logic [CNT_W-1:0] n_eff;
  logic [SLOTS-1:0] slot_valid;
  logic [63:0]      age_counter;
  logic [63:0]      stamp;

  lttc_req_t        cur;
  logic             reject;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_last;
  logic             pend;
  logic [IDX_W-1:0] rd_idx;

  logic             m_found, e_found, d_found;
  logic [IDX_W-1:0] m_idx, e_idx, d_idx, min_idx;
  logic [63:0]      min_age;

  logic             hit, hit_c;
  logic [IDX_W-1:0] tgt, tgt_c;
  logic [1:0]       kind, kind_c;

  lttc_entry_t      ent;
  lttc_entry_t      wr_ent;
  lttc_rsp_t        rsp_c;
  logic             act_fire;
  logic             bad_nodes;

  // Clamp the slot count to 1..SLOTS.
  always_comb begin
    if (slots_in_use == 7'd0) begin
      n_eff = CNT_W'(1);
    end else if ({{(32-7){1'b0}}, slots_in_use} > SLOTS) begin
      n_eff = CNT_W'(SLOTS);
    end else begin
      n_eff = CNT_W'(slots_in_use);
    end
  end

  assign scan_last = ({1'b0, scan_idx} == (n_eff - CNT_W'(1)));
  assign stamp     = (age_counter + 64'd1 == 64'd0) ? 64'd1 : age_counter + 64'd1;
  assign bad_nodes = (req.data.node_total == 9'd0) ||
                     (req.data.node_total > 9'(MAX_NODES));
  assign act_fire  = (state == ST_ACT) && (!rsp.valid || rsp.ready);
  assign cfg.ready = 1'b1;

  // A slot never written reads as empty and clean.
  always_comb begin
    ent = ram_rd_data;
    if (!slot_valid[rd_idx]) begin
      ent.age   = 64'd0;
      ent.nodes = 9'd0;
      ent.dirty = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.data.cmd == CMD_INSERT && bad_nodes) begin
            state_next = ST_ACT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FETCH;
      ST_FETCH: state_next = ST_ACT;
      ST_ACT:   if (act_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = scan_idx;
    ram_wr_en   = 1'b0;
    unique case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_SCAN:  ram_rd_en = 1'b1;
      ST_DRAIN: ram_rd_en = 1'b0;
      ST_FETCH: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = tgt_c;
      end
      ST_ACT:   ram_wr_en = act_fire && hit && !reject && (cur.cmd != CMD_FIND_DIRTY);
      default:  ram_rd_en = 1'b0;
    endcase
  end

  // Pick the slot the command acts on once the scan is through.
  always_comb begin
    hit_c  = m_found;
    tgt_c  = m_idx;
    kind_c = KIND_MATCH;
    unique case (cur.cmd)
      CMD_INSERT: begin
        hit_c = 1'b1;
        if (m_found) begin
          tgt_c  = m_idx;
          kind_c = KIND_MATCH;
        end else if (e_found) begin
          tgt_c  = e_idx;
          kind_c = KIND_EMPTY;
        end else begin
          tgt_c  = min_idx;
          kind_c = KIND_EVICT;
        end
      end
      CMD_FIND_DIRTY: begin
        hit_c = d_found;
        tgt_c = d_idx;
      end
      default: begin
        hit_c = m_found;
        tgt_c = m_idx;
      end
    endcase
  end

  always_comb begin
    wr_ent = ent;
    unique case (cur.cmd)
      CMD_LOOKUP: wr_ent.age = stamp;
      CMD_INSERT: begin
        if (kind != KIND_MATCH) begin
          wr_ent.level = cur.tree_level;
          wr_ent.tile  = cur.tile_number;
        end
        wr_ent.nodes = cur.node_total;
        wr_ent.dirty = cur.dirty_in;
        wr_ent.age   = stamp;
      end
      CMD_INVALIDATE: begin
        wr_ent.age   = 64'd0;
        wr_ent.nodes = 9'd0;
        wr_ent.dirty = 1'b0;
      end
      default: wr_ent = ent;
    endcase
  end

  assign ram_wr_addr = tgt;
  assign ram_wr_data = wr_ent;

  always_comb begin
    rsp_c = '0;
    if (hit && !reject) begin
      rsp_c.found       = 1'b1;
      rsp_c.slot_number = 6'(tgt);
      rsp_c.level_out   = wr_ent.level;
      rsp_c.tile_out    = wr_ent.tile;
      rsp_c.nodes_out   = wr_ent.nodes;
      rsp_c.dirty_out   = wr_ent.dirty;
    end
    if (cur.cmd == CMD_INSERT) begin
      rsp_c.insert_kind = reject ? KIND_REJECT : kind;
    end
    if (cur.cmd == CMD_FIND_DIRTY) begin
      rsp_c.next_scan = hit ? 7'({1'b0, tgt} + (IDX_W + 1)'(1)) : 7'(n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slots_in_use <= 7'd64;
      slot_valid   <= '0;
      age_counter  <= 64'd0;
      rsp.valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_SCAN);
      if (cfg.valid) begin
        slots_in_use <= cfg.data;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (act_fire) begin
        rsp.valid <= 1'b1;
      end
      if (ram_wr_en) begin
        slot_valid[tgt] <= 1'b1;
        if (cur.cmd != CMD_INVALIDATE) begin
          age_counter <= stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      rd_idx <= ram_rd_addr;
    end
    if (act_fire) begin
      rsp.data <= rsp_c;
    end
    if (state == ST_IDLE && req.valid) begin
      cur      <= req.data;
      reject   <= (req.data.cmd == CMD_INSERT) && bad_nodes;
      hit      <= 1'b0;
      scan_idx <= '0;
      m_found  <= 1'b0;
      e_found  <= 1'b0;
      d_found  <= 1'b0;
      m_idx    <= '0;
      e_idx    <= '0;
      d_idx    <= '0;
      min_idx  <= '0;
      min_age  <= '0;
    end
    if (state == ST_SCAN && !scan_last) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    // Fold each returned slot into the match, empty, oldest and dirty searches.
    if (pend) begin
      if (!m_found && ent.age != 64'd0 && ent.level == cur.tree_level &&
          ent.tile == cur.tile_number) begin
        m_found <= 1'b1;
        m_idx   <= rd_idx;
      end
      if (!e_found && ent.age == 64'd0) begin
        e_found <= 1'b1;
        e_idx   <= rd_idx;
      end
      if (rd_idx == '0 || ent.age < min_age) begin
        min_age <= ent.age;
        min_idx <= rd_idx;
      end
      if (!d_found && ent.age != 64'd0 && ent.dirty &&
          {1'b0, rd_idx} >= cur.scan_start) begin
        d_found <= 1'b1;
        d_idx   <= rd_idx;
      end
    end
    if (state == ST_FETCH) begin
      hit  <= hit_c;
      tgt  <= tgt_c;
      kind <= kind_c;
    end
  end

`ifndef SYNTH
  a_wr_only_in_act: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> state == ST_ACT)
    else $error("memory write outside act state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> {1'b0, scan_idx} < n_eff)
    else $error("scan index beyond slot count");

  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACT && reject) |-> !ram_wr_en)
    else $error("rejected insert wrote memory");

  a_rsp_from_act: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_ACT)
    else $error("response raised outside act state");
`endif
endmodule

// ===== rtl/core/lru_tile_tag_cache.sv =====
// Top level of the fully associative tile tag cache with timestamp LRU.
//
// Channels: req carries one command word (lookup, insert, invalidate,
// find next dirty) with its key and operands; rsp returns exactly one
// word per command; cfg writes slots_in_use at any handshake, and is
// meant to be written only while no command is in flight.
// Flow: after a command is taken, the tag entry of each of the first n
// slots, n being the effective slot count (1..64), is read once through
// the single read port of the tag memory; then the target slot is read
// again and, unless the command is find next dirty or misses, written
// back. A rejected insert skips the scan and goes straight to the act
// state. One command is in flight at a time.
// The response sits in an output register; a stalled receiver holds it
// there, and the next command may be taken and worked on meanwhile, but
// its response waits until the register is freed.
// Reset: all slots read as empty and clean through per-slot valid flags,
// the age counter is zero and slots_in_use returns to 64. No clearing
// pass is needed.
module lru_tile_tag_cache (
  input logic        clk,
  input logic        rst,
  lttc_req_if.sink   req,
  lttc_rsp_if.source rsp,
  lttc_cfg_if.sink   cfg
);
  import lttc_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  lttc_entry_t      wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  lttc_entry_t      rd_data;

  lttc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .ram_wr_en   (wr_en),
    .ram_wr_addr (wr_addr),
    .ram_wr_data (wr_data),
    .ram_rd_en   (rd_en),
    .ram_rd_addr (rd_addr),
    .ram_rd_data (rd_data)
  );

  lttc_ram #(
    .WIDTH ($bits(lttc_entry_t)),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );
endmodule

// ===== bench/lru_tile_tag_cache_tb.sv =====
// Testbench of the tile tag cache: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module lru_tile_tag_cache_tb;
  import lttc_pkg::*;

  class tag_scoreboard;
    logic [63:0] ages[SLOTS];
    logic [5:0]  levels[SLOTS];
    logic [62:0] tiles[SLOTS];
    logic [8:0]  nodes[SLOTS];
    logic        dirty[SLOTS];
    logic [63:0] stamp;
    logic [6:0]  slot_limit;
    lttc_rsp_t   expected_rsps[$];
    int          mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        ages[i] = '0; levels[i] = '0; tiles[i] = '0; nodes[i] = '0; dirty[i] = 1'b0;
      end
      stamp = '0;
      slot_limit = 7'd64;
      mismatches = 0;
    endfunction

    function int span();
      if (slot_limit == 7'd0) return 1;
      if (int'(slot_limit) > SLOTS) return SLOTS;
      return int'(slot_limit);
    endfunction

    function logic [63:0] bump();
      stamp = stamp + 64'd1;
      if (stamp == 64'd0) stamp = 64'd1;
      return stamp;
    endfunction

    function int match_slot(int n, logic [5:0] lvl, logic [62:0] tile);
      for (int i = 0; i < n; i++)
        if (ages[i] != 64'd0 && levels[i] == lvl && tiles[i] == tile) return i;
      return -1;
    endfunction

    function void fill(ref lttc_rsp_t r, input int s);
      r.found       = 1'b1;
      r.slot_number = s[5:0];
      r.level_out   = levels[s];
      r.tile_out    = tiles[s];
      r.nodes_out   = nodes[s];
      r.dirty_out   = dirty[s];
    endfunction

    function void note_request(lttc_req_t q);
      lttc_rsp_t r;
      int n, m, s;
      n = span();
      r = '0;
      m = match_slot(n, q.tree_level, q.tile_number);
      case (q.cmd)
        CMD_LOOKUP: begin
          if (m >= 0) begin
            ages[m] = bump();
            fill(r, m);
          end
        end
        CMD_INSERT: begin
          if (q.node_total == 9'd0 || int'(q.node_total) > MAX_NODES) begin
            r.insert_kind = KIND_REJECT;
          end else begin
            if (m >= 0) begin
              s = m;
              r.insert_kind = KIND_MATCH;
            end else begin
              s = -1;
              for (int i = 0; i < n; i++)
                if (s < 0 && ages[i] == 64'd0) s = i;
              if (s >= 0) begin
                r.insert_kind = KIND_EMPTY;
              end else begin
                s = 0;
                for (int i = 1; i < n; i++)
                  if (ages[i] < ages[s]) s = i;
                r.insert_kind = KIND_EVICT;
              end
              levels[s] = q.tree_level;
              tiles[s]  = q.tile_number;
            end
            nodes[s] = q.node_total;
            dirty[s] = q.dirty_in;
            ages[s]  = bump();
            fill(r, s);
          end
        end
        CMD_INVALIDATE: begin
          if (m >= 0) begin
            ages[m] = '0; nodes[m] = '0; dirty[m] = 1'b0;
            fill(r, m);
          end
        end
        default: begin
          r.next_scan = n[6:0];
          for (int i = int'(q.scan_start); i < n; i++)
            if (!r.found && ages[i] != 64'd0 && dirty[i]) begin
              fill(r, i);
              r.next_scan = 7'(i + 1);
            end
        end
      endcase
      expected_rsps.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_response(lttc_rsp_t got);
      lttc_rsp_t e;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected word", 64'(got.slot_number), 64'd0);
        return;
      end
      e = expected_rsps.pop_front();
      if (got.found !== e.found)
        report_mismatch("found", 64'(got.found), 64'(e.found));
      if (got.slot_number !== e.slot_number)
        report_mismatch("slot_number", 64'(got.slot_number), 64'(e.slot_number));
      if (got.level_out !== e.level_out)
        report_mismatch("level_out", 64'(got.level_out), 64'(e.level_out));
      if (got.tile_out !== e.tile_out)
        report_mismatch("tile_out", 64'(got.tile_out), 64'(e.tile_out));
      if (got.nodes_out !== e.nodes_out)
        report_mismatch("nodes_out", 64'(got.nodes_out), 64'(e.nodes_out));
      if (got.dirty_out !== e.dirty_out)
        report_mismatch("dirty_out", 64'(got.dirty_out), 64'(e.dirty_out));
      if (got.insert_kind !== e.insert_kind)
        report_mismatch("insert_kind", 64'(got.insert_kind), 64'(e.insert_kind));
      if (got.next_scan !== e.next_scan)
        report_mismatch("next_scan", 64'(got.next_scan), 64'(e.next_scan));
    endtask
  endclass

  logic clk;
  logic rst;
  lttc_req_if req ();
  lttc_rsp_if rsp ();
  lttc_cfg_if cfg ();
  tag_scoreboard sb = new();
  bit stall_free;
  logic [5:0]  key_level[12];
  logic [62:0] key_tile[12];

  lru_tile_tag_cache DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL lru_tile_tag_cache");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) sb.note_request(req.data);
    if (!rst && rsp.valid && rsp.ready) sb.check_response(rsp.data);
    if (!rst && cfg.valid && cfg.ready) sb.slot_limit = cfg.data;
  end

  function int pick_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 60);
  endfunction

  // Receiver: random stalls, with stall-free stretches.
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (stall_free) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 9) < 6) ? 1'b1 : ($urandom_range(0, 9) > 7);
  end

  initial begin
    stall_free = 1'b0;
    forever begin
      repeat ($urandom_range(200, 3000)) @(posedge clk);
      stall_free = ~stall_free;
    end
  end

  task send_word(lttc_req_t w, int gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= w;
    do @(posedge clk); while (!req.ready);
  endtask

  task quiet_and_write(logic [6:0] v);
    req.valid <= 1'b0;
    // Let the monitor note the last accepted word before checking the queue.
    @(posedge clk);
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  function lttc_req_t make_word(logic [1:0] c, logic [5:0] lvl, logic [62:0] tile,
                                logic [8:0] nd, logic d, logic [6:0] st);
    lttc_req_t w;
    w.cmd = c; w.tree_level = lvl; w.tile_number = tile;
    w.node_total = nd; w.dirty_in = d; w.scan_start = st;
    return w;
  endfunction

  function lttc_req_t random_word();
    int k;
    lttc_req_t w;
    k = $urandom_range(0, 11);
    w.cmd = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 85) begin
      w.tree_level = key_level[k]; w.tile_number = key_tile[k];
    end else begin
      w.tree_level = 6'($urandom); w.tile_number = 63'({$urandom, $urandom});
    end
    w.node_total = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                               : 9'($urandom_range(1, 256));
    w.dirty_in = 1'($urandom);
    w.scan_start = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(0, sb.span()));
    return w;
  endfunction

  initial begin
    logic [6:0] settings[8];
    logic [62:0] top_tile;
    settings = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd2, 7'd33, 7'd64};
    top_tile = '1;
    rst = 1'b1;
    req.valid = 1'b0; req.data = '0;
    cfg.valid = 1'b0; cfg.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: rejects, extremes, hit, rewrite, scans, invalidate.
    send_word(make_word(CMD_LOOKUP, 6'd5, 63'd9, 9'd1, 1'b0, 7'd0), 0);
    send_word(make_word(CMD_INSERT, 6'd5, 63'd9, 9'd0, 1'b1, 7'd0), 0);
    send_word(make_word(CMD_INSERT, 6'd5, 63'd9, 9'd257, 1'b1, 7'd0), 1);
    send_word(make_word(CMD_INSERT, 6'd5, 63'd9, 9'd511, 1'b1, 7'd0), 0);
    send_word(make_word(CMD_INSERT, 6'd63, top_tile, 9'd256, 1'b1, 7'd0), 0);
    send_word(make_word(CMD_INSERT, 6'd0, 63'd0, 9'd1, 1'b0, 7'd0), 3);
    send_word(make_word(CMD_LOOKUP, 6'd63, top_tile, 9'd0, 1'b0, 7'd0), 0);
    send_word(make_word(CMD_INSERT, 6'd0, 63'd0, 9'd200, 1'b1, 7'd0), 0);
    send_word(make_word(CMD_FIND_DIRTY, 6'd0, 63'd0, 9'd0, 1'b0, 7'd0), 0);
    send_word(make_word(CMD_FIND_DIRTY, 6'd0, 63'd0, 9'd0, 1'b0, 7'd1), 0);
    send_word(make_word(CMD_FIND_DIRTY, 6'd0, 63'd0, 9'd0, 1'b0, 7'd2), 0);
    send_word(make_word(CMD_FIND_DIRTY, 6'd0, 63'd0, 9'd0, 1'b0, 7'd64), 0);
    send_word(make_word(CMD_FIND_DIRTY, 6'd0, 63'd0, 9'd0, 1'b0, 7'd127), 0);
    send_word(make_word(CMD_INVALIDATE, 6'd63, top_tile, 9'd0, 1'b0, 7'd0), 0);
    send_word(make_word(CMD_INVALIDATE, 6'd63, top_tile, 9'd0, 1'b0, 7'd0), 0);
    send_word(make_word(CMD_LOOKUP, 6'd63, top_tile, 9'd0, 1'b0, 7'd0), 0);
    send_word(make_word(CMD_INSERT, 6'd1, 63'd3, 9'd17, 1'b0, 7'd0), 0);
    send_word(make_word(CMD_FIND_DIRTY, 6'd0, 63'd0, 9'd0, 1'b0, 7'd0), 0);

    foreach (settings[p]) begin
      quiet_and_write(settings[p]);
      for (int k = 0; k < 12; k++) begin
        key_level[k] = 6'($urandom);
        key_tile[k]  = 63'({$urandom, $urandom});
      end
      // Small counts evict often; bias them toward inserts.
      for (int i = 0; i < 75; i++) begin
        lttc_req_t w;
        w = random_word();
        if (sb.span() < 64 && $urandom_range(0, 2) == 0) w.cmd = CMD_INSERT;
        send_word(w, pick_gap());
      end
    end
    req.valid <= 1'b0;

    @(posedge clk);
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS lru_tile_tag_cache");
    end else begin
      $display("FAIL lru_tile_tag_cache");
    end
    $finish;
  end

endmodule

// ===== lru_tile_tag_cache.f =====
rtl/core/lttc_pkg.sv
rtl/core/lttc_ifs.sv
rtl/core/lttc_ram.sv
rtl/core/lttc_ctrl.sv
rtl/core/lru_tile_tag_cache.sv
bench/lru_tile_tag_cache_tb.sv
